@@ src/bptt_pkg.sv @@
// Package for the blind position and tilt tracker.
// Holds the fixed-point constants, the operation and state codes and the
// transaction payload types. Depends on nothing.
`default_nettype none

package bptt_pkg;

    // Fixed-point format: unsigned, FRAC_BITS fraction bits, FRAC_ONE is fully open.
    localparam int FRAC_BITS = 24;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

    // Restore thresholds: 5 % and 95 % of full travel.
    localparam logic [FRAC_W-1:0] POS_LOW_LIMIT  = FRAC_W'(longint'(FRAC_ONE) / 20);
    localparam logic [FRAC_W-1:0] POS_HIGH_LIMIT = FRAC_W'((longint'(FRAC_ONE) * 19) / 20);

    // Periodic publish interval and the width of its counter, which saturates
    // at one past the interval.
    localparam int PUB_INTERVAL_MS = 100;
    localparam int PUB_W           = $clog2(PUB_INTERVAL_MS + 2);

    localparam int STEP_W     = 18;
    localparam int WAIT_W     = 16;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int OP_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_STEP   = 3'd0,
        CFG_CLOSE_STEP  = 3'd1,
        CFG_TILT_STEP   = 3'd2,
        CFG_INTERLOCK   = 3'd3,
        CFG_HAS_ENDSTOP = 3'd4,
        CFG_MANUAL      = 3'd5
    } t_cfg_idx;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_STOP     = 3'd1,
        OP_TOGGLE   = 3'd2,
        OP_SET_TILT = 3'd3,
        OP_SET_POS  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        MOT_IDLE  = 2'd0,
        MOT_OPEN  = 2'd1,
        MOT_CLOSE = 2'd2
    } t_motion;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_OPEN  = 2'd2,
        CMD_CLOSE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_POS  = 2'd1,
        PH_TILT = 2'd2
    } t_phase;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [FRAC_W-1:0] target_value;
    } t_in;

    typedef struct packed {
        logic [1:0]        motor_state;
        logic [1:0]        drive_command;
        logic [FRAC_W-1:0] position_now;
        logic [FRAC_W-1:0] tilt_now;
        logic              publish;
    } t_out;

endpackage

`default_nettype wire

@@ src/blind_position_tilt_tracker.sv @@
// Top level of the blind position and tilt tracker: input register, the
// single-pass state update and the result register. Depends on bptt_pkg.
`default_nettype none

// Channel     | Signals                                  | Direction
// ------------+------------------------------------------+----------
// item in     | i_in_valid, o_in_ready, i_in_data        | in
// result out  | o_out_valid, i_out_ready, o_out_data     | out
// config      | i_cfg_we, i_cfg_index, i_cfg_data        | in
//
// Each transaction is taken into an input register; once the output register
// can take it, the whole state update is worked out in one pass and the result
// is written to the output register, so the block sustains one item per cycle
// unless the output stalls. The input register refills in the same cycle that it
// drains, so a new item is taken while a finished result still waits downstream.
// Reset is synchronous and active low; it restores the power-on estimates (fully
// open, slats closed) and the default step sizes. A stalled output holds both
// registers and lowers o_in_ready once the input register is also full.

module blind_position_tilt_tracker
    import bptt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Motion, last running direction and the command issued so far in the item.
    typedef struct packed {
        t_motion motion;
        t_motion prev;
        t_cmd    cmd;
    } t_drv;

    // Configuration registers.
    logic [STEP_W-1:0] r_open_step;
    logic [STEP_W-1:0] r_close_step;
    logic [STEP_W-1:0] r_tilt_step;
    logic [WAIT_W-1:0] r_wait_ms;
    logic              r_has_endstop;
    logic              r_manual;

    // Pipeline registers.
    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;

    // Tracker state.
    logic [FRAC_W-1:0] r_pos, n_pos;
    logic [FRAC_W-1:0] r_tilt, n_tilt;
    logic [FRAC_W-1:0] r_goal_pos, n_goal_pos;
    logic [FRAC_W-1:0] r_goal_tilt, n_goal_tilt;
    t_motion           r_motion;
    t_motion           r_prev_motion;
    t_phase            r_phase, n_phase;
    logic              r_ilk_active, n_ilk_active;
    logic [WAIT_W-1:0] r_ilk_elapsed, n_ilk_elapsed;
    logic [PUB_W-1:0]  r_pub_elapsed, n_pub_elapsed;

    t_drv              s_drv;
    logic              s_pub;
    logic              s_quiet;
    logic              s_up;
    logic              s_at;
    logic [FRAC_W-1:0] s_tv;
    logic              s_advance;

    // Saturating ramp of a fraction by one step, towards open or closed.
    function automatic logic [FRAC_W-1:0] f_ramp(input logic [FRAC_W-1:0] v,
                                                 input logic [STEP_W-1:0] step,
                                                 input logic              up);
        logic [FRAC_W:0] sum;
        sum = {1'b0, v} + (FRAC_W + 1)'(step);
        if (up) begin
            return (sum > {1'b0, FRAC_ONE}) ? FRAC_ONE : sum[FRAC_W-1:0];
        end
        return (FRAC_W'(step) > v) ? '0 : v - FRAC_W'(step);
    endfunction

    // Issue a motor command; starting the direction already running is ignored.
    function automatic t_drv f_drive(input t_motion dir, input t_drv cur);
        t_drv res;
        res = cur;
        if (!(dir == cur.motion && dir != MOT_IDLE)) begin
            if (dir == MOT_IDLE) begin
                res.cmd = CMD_STOP;
            end else begin
                res.prev = dir;
                if (dir == MOT_OPEN) begin
                    res.cmd = CMD_OPEN;
                end else begin
                    res.cmd = CMD_CLOSE;
                end
            end
            res.motion = dir;
        end
        return res;
    endfunction

    function automatic logic f_is_end(input logic [FRAC_W-1:0] v);
        return (v == '0) || (v == FRAC_ONE);
    endfunction

    // Handshake: the input register drains whenever the output register is
    // free or being emptied in the same cycle.
    assign s_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || s_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Requests beyond fully open are clipped.
    assign s_tv = (r_in.target_value > FRAC_ONE) ? FRAC_ONE : r_in.target_value;

    // One pass of the state update for the item held in the input register.
    always_comb begin
        n_pos         = r_pos;
        n_tilt        = r_tilt;
        n_goal_pos    = r_goal_pos;
        n_goal_tilt   = r_goal_tilt;
        n_phase       = r_phase;
        n_ilk_active  = r_ilk_active;
        n_ilk_elapsed = r_ilk_elapsed;
        n_pub_elapsed = r_pub_elapsed;
        s_drv         = '{motion: r_motion, prev: r_prev_motion, cmd: CMD_NONE};
        s_pub         = 1'b0;
        s_quiet       = 1'b0;
        s_up          = (r_motion == MOT_OPEN);
        s_at          = 1'b1;

        case (r_in.operation)
            OP_TICK: begin
                if (r_pub_elapsed <= PUB_W'(PUB_INTERVAL_MS)) begin
                    n_pub_elapsed = r_pub_elapsed + PUB_W'(1);
                end
                if (r_motion == MOT_IDLE && !r_ilk_active) begin
                    // Idle with no interlock pending: only the publish timer runs.
                    s_quiet = 1'b1;
                end else begin
                    // Tilt ramps first; position moves only with the slats at an end.
                    if (r_motion == MOT_OPEN || r_motion == MOT_CLOSE) begin
                        n_tilt = f_ramp(r_tilt, r_tilt_step, s_up);
                        if (f_is_end(n_tilt)) begin
                            n_pos = f_ramp(r_pos, s_up ? r_open_step : r_close_step, s_up);
                        end
                    end

                    if (r_motion == MOT_OPEN) begin
                        if (r_phase == PH_POS) begin
                            s_at = (n_pos >= r_goal_pos);
                        end else if (r_phase == PH_TILT) begin
                            s_at = (n_tilt >= r_goal_tilt);
                        end
                    end else if (r_motion == MOT_CLOSE) begin
                        if (r_phase == PH_POS) begin
                            s_at = (n_pos <= r_goal_pos);
                        end else if (r_phase == PH_TILT) begin
                            s_at = (n_tilt <= r_goal_tilt);
                        end
                    end

                    if (s_at) begin
                        // With end stops the motor halts by itself at an end.
                        if (r_has_endstop && f_is_end(r_goal_pos)) begin
                            s_drv.motion = MOT_IDLE;
                        end else begin
                            s_drv = f_drive(MOT_IDLE, s_drv);
                        end

                        if (r_phase == PH_TILT) begin
                            n_tilt = r_goal_tilt;
                        end else if (n_tilt != r_goal_tilt) begin
                            if (!r_ilk_active) begin
                                // First tick at target arms the interlock wait.
                                n_ilk_active  = 1'b1;
                                n_ilk_elapsed = '0;
                                s_quiet       = 1'b1;
                            end else begin
                                if (r_ilk_elapsed < {WAIT_W{1'b1}}) begin
                                    n_ilk_elapsed = r_ilk_elapsed + WAIT_W'(1);
                                end
                                if (n_ilk_elapsed < r_wait_ms) begin
                                    s_quiet = 1'b1;
                                end else begin
                                    // Wait over: reverse to restore the tilt unless
                                    // the blind sits close to an end stop.
                                    n_ilk_active  = 1'b0;
                                    n_ilk_elapsed = '0;
                                    if (s_drv.prev == MOT_CLOSE && n_pos > POS_LOW_LIMIT) begin
                                        s_drv = f_drive(MOT_OPEN, s_drv);
                                    end else if (s_drv.prev == MOT_OPEN &&
                                                 n_pos <= POS_HIGH_LIMIT) begin
                                        s_drv = f_drive(MOT_CLOSE, s_drv);
                                    end
                                    n_phase = PH_TILT;
                                end
                            end
                        end else begin
                            n_phase = PH_IDLE;
                        end

                        if (!s_quiet) begin
                            s_pub = 1'b1;
                        end
                    end
                end

                if (!s_quiet && n_pub_elapsed > PUB_W'(PUB_INTERVAL_MS)) begin
                    s_pub         = 1'b1;
                    n_pub_elapsed = '0;
                end
            end

            OP_STOP: begin
                s_drv = f_drive(MOT_IDLE, s_drv);
                s_pub = 1'b1;
            end

            OP_TOGGLE: begin
                if (r_motion != MOT_IDLE) begin
                    s_drv = f_drive(MOT_IDLE, s_drv);
                    s_pub = 1'b1;
                end else if (r_pos == '0 || r_prev_motion == MOT_CLOSE) begin
                    n_goal_pos = FRAC_ONE;
                    s_drv      = f_drive(MOT_OPEN, s_drv);
                end else begin
                    n_goal_pos = '0;
                    s_drv      = f_drive(MOT_CLOSE, s_drv);
                end
            end

            OP_SET_TILT: begin
                n_goal_tilt = s_tv;
                if (s_tv > r_tilt) begin
                    n_phase = PH_TILT;
                    s_drv   = f_drive(MOT_OPEN, s_drv);
                end else if (s_tv < r_tilt) begin
                    n_phase = PH_TILT;
                    s_drv   = f_drive(MOT_CLOSE, s_drv);
                end
            end

            OP_SET_POS: begin
                if (s_tv == r_pos) begin
                    // Already there: only an end command with a manual switch or
                    // end stops drives the motor.
                    if (r_manual && f_is_end(s_tv)) begin
                        n_pos      = (s_tv == '0) ? FRAC_ONE : '0;
                        n_goal_pos = s_tv;
                        s_drv      = f_drive((s_tv == '0) ? MOT_CLOSE : MOT_OPEN, s_drv);
                    end
                    if (r_has_endstop && f_is_end(s_tv)) begin
                        n_goal_pos = s_tv;
                        s_drv      = f_drive((s_tv == '0) ? MOT_CLOSE : MOT_OPEN, s_drv);
                    end
                end else begin
                    if (r_manual && f_is_end(s_tv)) begin
                        n_pos = (s_tv == '0) ? FRAC_ONE : '0;
                    end
                    n_goal_pos = s_tv;
                    s_drv      = f_drive((s_tv < r_pos) ? MOT_CLOSE : MOT_OPEN, s_drv);
                    n_phase    = PH_POS;
                end
            end

            default: begin
            end
        endcase
    end

    // Control state, configuration and tracker state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_open_step   <= STEP_W'(1678);
            r_close_step  <= STEP_W'(1678);
            r_tilt_step   <= STEP_W'(16777);
            r_wait_ms     <= '0;
            r_has_endstop <= 1'b0;
            r_manual      <= 1'b0;
            r_pos         <= FRAC_ONE;
            r_tilt        <= '0;
            r_goal_pos    <= '0;
            r_goal_tilt   <= '0;
            r_motion      <= MOT_IDLE;
            r_prev_motion <= MOT_IDLE;
            r_phase       <= PH_IDLE;
            r_ilk_active  <= 1'b0;
            r_ilk_elapsed <= '0;
            r_pub_elapsed <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (s_advance) begin
                r_in_valid <= 1'b0;
            end

            if (s_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OPEN_STEP:   r_open_step   <= i_cfg_data[STEP_W-1:0];
                    CFG_CLOSE_STEP:  r_close_step  <= i_cfg_data[STEP_W-1:0];
                    CFG_TILT_STEP:   r_tilt_step   <= i_cfg_data[STEP_W-1:0];
                    CFG_INTERLOCK:   r_wait_ms     <= i_cfg_data[WAIT_W-1:0];
                    CFG_HAS_ENDSTOP: r_has_endstop <= i_cfg_data[0];
                    CFG_MANUAL:      r_manual      <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (s_advance) begin
                r_pos         <= n_pos;
                r_tilt        <= n_tilt;
                r_goal_pos    <= n_goal_pos;
                r_goal_tilt   <= n_goal_tilt;
                r_motion      <= s_drv.motion;
                r_prev_motion <= s_drv.prev;
                r_phase       <= n_phase;
                r_ilk_active  <= n_ilk_active;
                r_ilk_elapsed <= n_ilk_elapsed;
                r_pub_elapsed <= n_pub_elapsed;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (s_advance) begin
            r_out.motor_state   <= s_drv.motion;
            r_out.drive_command <= s_drv.cmd;
            r_out.position_now  <= n_pos;
            r_out.tilt_now      <= n_tilt;
            r_out.publish       <= s_pub;
        end
    end

endmodule

`default_nettype wire
